>>> design/tsst_pkg.sv
// Package for the timed signature spacing table.
// Holds table geometry, stream field widths and the result type.
package tsst_pkg;
	localparam int unsigned TableEntries = 64;
	localparam int unsigned IdxW = $clog2(TableEntries);
	localparam int unsigned CntW = $clog2(TableEntries + 1);
	localparam int unsigned KeyW = 512;
	localparam int unsigned StampW = 48;
	localparam int unsigned DelayW = 32;
	localparam int unsigned InDataW = 560;
	localparam int unsigned OutDataW = 16;
	localparam int unsigned LiveW = 7;
	localparam logic FUNC_QUERY = 1'b0;
	localparam logic FUNC_FLAG = 1'b1;

	typedef struct packed {
		logic votable;
		logic newly_inserted;
		logic replaced_oldest;
		logic [LiveW-1:0] live_count;
	} result_t;
endpackage

>>> design/tsst_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Standalone; used for the key and stamp stores.
module tsst_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

>>> design/timed_signature_spacing_table.sv
// Top level of the timed signature spacing table.
// Depends on tsst_pkg and tsst_ram.
//
//  channel  | direction | contents
//  s_axis   | in        | tuser=func, tdata=now_ms then sig_word0..7
//  m_axis   | out       | tdata=votable,newly_inserted,replaced_oldest,live_count
//  cfg      | in        | spacing_delay_ms write
//
// An item is taken in the idle state and then sweeps the key and stamp memories,
// one entry per cycle through the single RAM port. As the read data is registered,
// the compare runs one entry behind the address, and the end of the sweep is seen
// after the last compare; the write-back state and then the done state, which loads
// the result, follow. The next item can be taken once the block is back in idle.
// Reset clears the valid bits, the count and the delay at once; the stores need no
// clearing. A result waits in an output register, and the next item is taken while
// it waits; a new result is only produced once the previous one has gone.
module timed_signature_spacing_table (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [tsst_pkg::DelayW-1:0] cfg_wdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// bits: now_ms[47:0], sig_word0..sig_word7[559:48]
	input  logic [tsst_pkg::InDataW-1:0] s_axis_tdata,
	// bits: func[0]
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// bits: votable[0], newly_inserted[1], replaced_oldest[2], live_count[9:3], zero
	output logic [tsst_pkg::OutDataW-1:0] m_axis_tdata
);
	import tsst_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [DelayW-1:0] delay_q;
	logic [TableEntries-1:0] valid_q;
	logic [CntW-1:0] occ_q;
	logic func_q;
	logic [StampW-1:0] now_q;
	logic [KeyW-1:0] key_q;
	// Address counter runs one ahead of the compare, which sees the read data.
	logic [CntW-1:0] addr_q;
	logic cmp_q;
	logic [IdxW-1:0] cidx_q;
	logic hit_q, free_q;
	logic [IdxW-1:0] hidx_q, fidx_q, oidx_q;
	logic [StampW-1:0] ostamp_q;
	logic have_old_q;
	logic out_v_q;
	result_t res_q;

	logic [IdxW-1:0] ram_addr;
	logic ram_we;
	logic [KeyW-1:0] key_rd;
	logic [StampW-1:0] stamp_rd;
	logic [IdxW-1:0] wr_idx;

	assign wr_idx = hit_q ? hidx_q : (free_q ? fidx_q : oidx_q);
	assign ram_we = (state_q == ST_WRITE) && (func_q == FUNC_FLAG);
	assign ram_addr = ram_we ? wr_idx : addr_q[IdxW-1:0];

	tsst_ram #(.Width(KeyW), .Depth(TableEntries)) u_key (
		.clk(clk), .we(ram_we && !hit_q), .addr(ram_addr), .wdata(key_q), .rdata(key_rd)
	);
	tsst_ram #(.Width(StampW), .Depth(TableEntries)) u_stamp (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(now_q), .rdata(stamp_rd)
	);

	// Expiry without wrap: stamp + delay is taken at 49 bits.
	logic [StampW:0] lim;
	logic expired, live_e;
	assign lim = {1'b0, stamp_rd} + {{(StampW+1-DelayW){1'b0}}, delay_q};
	assign expired = lim < {1'b0, now_q};
	assign live_e = valid_q[cidx_q] && !expired;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {6'd0, res_q.live_count, res_q.replaced_oldest,
		res_q.newly_inserted, res_q.votable};

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			func_q <= s_axis_tuser;
			now_q <= s_axis_tdata[StampW-1:0];
			key_q <= s_axis_tdata[StampW +: KeyW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			delay_q <= '0;
			valid_q <= '0;
			occ_q <= '0;
			addr_q <= '0;
			cmp_q <= 1'b0;
			cidx_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			hidx_q <= '0;
			fidx_q <= '0;
			oidx_q <= '0;
			ostamp_q <= '0;
			have_old_q <= 1'b0;
			out_v_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (cfg_we) begin
				delay_q <= cfg_wdata;
			end
			// In the done state the result load below decides the valid flag.
			if (out_v_q && m_axis_tready && state_q != ST_DONE) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_SCAN;
						addr_q <= '0;
						cmp_q <= 1'b0;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						have_old_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (addr_q < CntW'(TableEntries)) begin
						addr_q <= addr_q + 1'b1;
					end
					cmp_q <= (addr_q < CntW'(TableEntries));
					cidx_q <= addr_q[IdxW-1:0];
					if (cmp_q) begin
						if (valid_q[cidx_q] && expired) begin
							valid_q[cidx_q] <= 1'b0;
							occ_q <= occ_q - 1'b1;
						end
						if (live_e && !hit_q && key_rd == key_q) begin
							hit_q <= 1'b1;
							hidx_q <= cidx_q;
						end
						if (!live_e && !free_q) begin
							free_q <= 1'b1;
							fidx_q <= cidx_q;
						end
						if (live_e && (!have_old_q || stamp_rd < ostamp_q)) begin
							have_old_q <= 1'b1;
							ostamp_q <= stamp_rd;
							oidx_q <= cidx_q;
						end
					end
					if (!cmp_q && addr_q == CntW'(TableEntries)) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (func_q == FUNC_FLAG && !hit_q) begin
						valid_q[wr_idx] <= 1'b1;
						if (free_q) begin
							occ_q <= occ_q + 1'b1;
						end
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_v_q || m_axis_tready) begin
						out_v_q <= 1'b1;
						res_q.votable <= (func_q == FUNC_QUERY) && !hit_q;
						res_q.newly_inserted <= (func_q == FUNC_FLAG) && !hit_q;
						res_q.replaced_oldest <= (func_q == FUNC_FLAG) && !hit_q && !free_q;
						res_q.live_count <= LiveW'(occ_q);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> design/tsst_checker.sv
// Port-level checks for the timed signature spacing table.
// Depends on tsst_pkg; bound to the top level below.
module tsst_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [tsst_pkg::OutDataW-1:0] m_axis_tdata
);
	import tsst_pkg::*;

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[9:3] <= 7'(TableEntries))
		else $error("live count beyond table size");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
		else $error("votable and inserted together");
	a_rep: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[2]) |-> m_axis_tdata[1])
		else $error("replacement without insertion");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("second item taken during a sweep");
endmodule

bind timed_signature_spacing_table tsst_checker u_tsst_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
